### design/tsr_pkg.sv
// Types, codes and constants shared by the traffic slot table.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package tsr_pkg;

    // Default table depth
    localparam int unsigned NUM_SLOTS_DEF = 8;

    // Register reset values
    localparam logic [15:0] RANGE_LIMIT_RST  = 16'd15000;
    localparam logic        FILTER_EN_RST    = 1'b0;
    localparam logic [14:0] VERT_WINDOW_RST  = 15'd500;
    localparam logic [7:0]  EXPIRE_TIME_RST  = 8'd5;

    // APB address width: four registers at 4-byte spacing
    localparam int unsigned APB_AW = 4;

    typedef enum logic [1:0] {
        REG_RANGE_LIMIT = 2'd0,
        REG_FILTER_EN   = 2'd1,
        REG_VERT_WINDOW = 2'd2,
        REG_EXPIRE_TIME = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ACT_DROP     = 3'd0,
        ACT_UPDATE   = 3'd1,
        ACT_EMPTY    = 3'd2,
        ACT_EXPIRED  = 3'd3,
        ACT_LOWEST   = 3'd4,
        ACT_FARTHEST = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

    // Input word: one traffic report
    typedef struct packed {
        logic [23:0]        target_id;
        logic [31:0]        report_time;
        logic [31:0]        own_time;
        logic [15:0]        target_distance;
        logic signed [15:0] vertical_offset;
        logic [1:0]         alarm_lvl;
        logic [7:0]         alert_flags;
        logic [1:0]         alert_lvl;
    } t_report;

    // Output word: what happened to the report
    typedef struct packed {
        t_action     action;
        logic [2:0]  slot;
        logic [7:0]  kept_alert_flags;
        logic [1:0]  kept_alert_level;
    } t_result;

    // One table entry as held in the slot memory
    typedef struct packed {
        logic [23:0] id;
        logic [31:0] rtime;
        logic [15:0] distance;
        logic [1:0]  alarm;
        logic [7:0]  alert_flags;
        logic [1:0]  alert_lvl;
    } t_entry;

endpackage

`default_nettype wire

### design/traffic_slot_replacement.sv
// Traffic slot table: range/window filter, id match, slot replacement policy.
// Depends on tsr_pkg; slot state lives in one synchronous memory in this module.
//
//   channel   | signals                                | word
//   ----------+----------------------------------------+-----------
//   report in | i_in_valid / o_in_ready / i_report      | t_report
//   result    | o_out_valid / i_out_ready / o_result    | t_result
//   config    | psel penable pwrite paddr pwdata prdata pready (APB)
//
// Each report passes idle (where it is taken), then scan, with one read of the
// slot memory per slot, then drain for the last read data, then decide, which
// decides and writes back and waits while the output register is still full.
// The result word is registered in the decide state. Reports are handled one at a time.
// Reset (synchronous, active low) clears the per-slot valid bits, so the table
// reads empty at once; no clearing pass. A stalled result holds in the output
// register while the next report is already taken and scanned.
`default_nettype none

module traffic_slot_replacement
    import tsr_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // report channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_report           i_report,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_result                o_result,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int unsigned IW = $clog2(NUM_SLOTS);

    // ---------------- configuration registers ----------------
    logic [15:0] r_range;
    logic        r_filt;
    logic [14:0] r_vwin;
    logic [7:0]  r_expire;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range  <= RANGE_LIMIT_RST;
            r_filt   <= FILTER_EN_RST;
            r_vwin   <= VERT_WINDOW_RST;
            r_expire <= EXPIRE_TIME_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_RANGE_LIMIT: r_range  <= pwdata[15:0];
                REG_FILTER_EN:   r_filt   <= pwdata[0];
                REG_VERT_WINDOW: r_vwin   <= pwdata[14:0];
                REG_EXPIRE_TIME: r_expire <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (cfg_idx)
            REG_RANGE_LIMIT: prdata = {16'd0, r_range};
            REG_FILTER_EN:   prdata = {31'd0, r_filt};
            REG_VERT_WINDOW: prdata = {17'd0, r_vwin};
            REG_EXPIRE_TIME: prdata = {24'd0, r_expire};
            default:         prdata = 32'd0;
        endcase
    end

    // ---------------- control ----------------
    t_state  r_state, n_state;
    logic    in_fire;
    logic    out_free;
    logic    scan_last;
    logic    dec_fire;
    logic [IW-1:0] r_addr;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_free  = !o_out_valid || i_out_ready;
    assign scan_last = (r_addr == IW'(NUM_SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        dec_fire   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                // wait for the output register to free up
                if (out_free) begin
                    dec_fire = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // scan address: one slot read per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (in_fire) begin
            r_addr <= '0;
        end else if (r_state == S_SCAN && !scan_last) begin
            r_addr <= r_addr + IW'(1);
        end
    end

    // ---------------- captured report and filter result ----------------
    t_report            r_in;
    logic               r_drop;
    logic signed [16:0] vert_ext;
    logic signed [16:0] win_pos;
    logic signed [16:0] win_neg;
    logic               out_of_win;

    assign vert_ext   = 17'($signed(i_report.vertical_offset));
    assign win_pos    = signed'({2'b00, r_vwin});
    assign win_neg    = -win_pos;
    assign out_of_win = !(vert_ext > win_neg && vert_ext < win_pos);

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in   <= i_report;
            r_drop <= (i_report.target_distance > r_range) || (r_filt && out_of_win);
        end
    end

    // ---------------- slot memory ----------------
    t_entry             r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;
    t_entry             r_q;
    logic               r_q_vld;
    logic [IW-1:0]      r_q_idx;
    logic               r_q_use;
    t_entry             q_ent;

    logic               dec_wr;
    logic [IW-1:0]      dec_idx;
    t_entry             dec_ent;

    // write port, one read port with registered data.
    // Write happens only in the decide cycle, after the scan's last read,
    // so no access of one report overlaps the next.
    always_ff @(posedge i_clk) begin
        if (dec_fire && dec_wr) begin
            r_mem[dec_idx] <= dec_ent;
        end
        r_q     <= r_mem[r_addr];
        r_q_vld <= r_valid[r_addr];
        r_q_idx <= r_addr;
    end

    // valid bits: an unwritten slot reads as all zero (empty)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_q_use <= 1'b0;
        end else begin
            if (dec_fire && dec_wr) r_valid[dec_idx] <= 1'b1;
            r_q_use <= (r_state == S_SCAN);
        end
    end

    assign q_ent = r_q_vld ? r_q : '0;

    // ---------------- scan accumulators ----------------
    logic          r_match_hit;
    logic [IW-1:0] r_match_idx;
    logic [7:0]    r_match_flags;
    logic [1:0]    r_match_level;
    logic          r_free_hit;
    t_action       r_free_act;
    logic [IW-1:0] r_free_idx;
    logic [15:0]   r_far_dist;
    logic [IW-1:0] r_far_idx;
    logic [1:0]    r_far_alarm;
    logic [1:0]    r_low_alarm;
    logic [IW-1:0] r_low_idx;
    logic          q_expired;

    assign q_expired = 33'(r_in.own_time) > (33'(q_ent.rtime) + 33'(r_expire));

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
            r_far_dist  <= '0;
            r_far_idx   <= '0;
            r_low_alarm <= 2'd3;
            r_low_idx   <= '0;
        end else if (r_q_use) begin
            // first slot holding this id
            if (!r_match_hit && q_ent.id == r_in.target_id) begin
                r_match_hit   <= 1'b1;
                r_match_idx   <= r_q_idx;
                r_match_flags <= q_ent.alert_flags;
                r_match_level <= q_ent.alert_lvl;
            end
            // first empty or expired slot, empty tested first
            if (!r_free_hit) begin
                if (q_ent.id == '0) begin
                    r_free_hit <= 1'b1;
                    r_free_act <= ACT_EMPTY;
                    r_free_idx <= r_q_idx;
                end else if (q_expired) begin
                    r_free_hit <= 1'b1;
                    r_free_act <= ACT_EXPIRED;
                    r_free_idx <= r_q_idx;
                end
            end
            // farthest and lowest alarm, ties keep the lower slot
            if (q_ent.distance > r_far_dist) begin
                r_far_dist  <= q_ent.distance;
                r_far_idx   <= r_q_idx;
                r_far_alarm <= q_ent.alarm;
            end
            if (q_ent.alarm < r_low_alarm) begin
                r_low_alarm <= q_ent.alarm;
                r_low_idx   <= r_q_idx;
            end
        end
    end

    // ---------------- decision ----------------
    t_action  dec_act;
    t_result  dec_res;

    always_comb begin
        dec_act = ACT_DROP;
        dec_idx = '0;
        dec_wr  = 1'b0;
        dec_ent.id          = r_in.target_id;
        dec_ent.rtime       = r_in.report_time;
        dec_ent.distance    = r_in.target_distance;
        dec_ent.alarm       = r_in.alarm_lvl;
        dec_ent.alert_flags = r_in.alert_flags;
        dec_ent.alert_lvl   = r_in.alert_lvl;
        if (r_drop) begin
            dec_act = ACT_DROP;
        end else if (r_match_hit) begin
            // update keeps the stored alert marks
            dec_act = ACT_UPDATE;
            dec_idx = r_match_idx;
            dec_wr  = 1'b1;
            dec_ent.alert_flags = r_match_flags;
            dec_ent.alert_lvl   = r_match_level;
        end else if (r_free_hit) begin
            dec_act = r_free_act;
            dec_idx = r_free_idx;
            dec_wr  = 1'b1;
        end else if (r_in.alarm_lvl > r_low_alarm) begin
            dec_act = ACT_LOWEST;
            dec_idx = r_low_idx;
            dec_wr  = 1'b1;
        end else if (r_in.target_distance < r_far_dist &&
                     r_in.alarm_lvl >= r_far_alarm) begin
            dec_act = ACT_FARTHEST;
            dec_idx = r_far_idx;
            dec_wr  = 1'b1;
        end

        dec_res.action = dec_act;
        if (dec_wr) begin
            dec_res.slot             = 3'(dec_idx);
            dec_res.kept_alert_flags = dec_ent.alert_flags;
            dec_res.kept_alert_level = dec_ent.alert_lvl;
        end else begin
            dec_res.slot             = '0;
            dec_res.kept_alert_flags = '0;
            dec_res.kept_alert_level = '0;
        end
    end

    // ---------------- output register ----------------
    logic    r_out_valid;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (dec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_fire) r_out <= dec_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

### design/tsr_checker.sv
// Port-level checks for the traffic slot table, bound to the top level.
// Depends on tsr_pkg and the port list of traffic_slot_replacement.
`default_nettype none

module tsr_checker
    import tsr_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire t_result           o_result
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result))
        else $error("result word changed while stalled");

    // a dropped report names no slot and no alert marks
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.action == ACT_DROP |->
            o_result.slot == 3'd0 && o_result.kept_alert_flags == 8'd0 &&
            o_result.kept_alert_level == 2'd0)
        else $error("dropped report carries slot data");

    // one report at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("report accepted while scan in progress");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

bind traffic_slot_replacement tsr_checker u_tsr_checker (.*);

`default_nettype wire
